>>> hw/rtl/sohist_pkg.sv
// ============================================================================
// sohist_pkg: shared types, codes and microcode ROM for the offset histogram
// Holds the op and region codes, register indexes, the control word layout
// and the sequencer program that drives the histogram datapath.
// ============================================================================
package sohist_pkg;

    localparam int MAX_BUCKETS_DEFAULT = 64;

    localparam int OP_W     = 2;
    localparam int ERR_W    = 32;
    localparam int RIDX_W   = 7;
    localparam int REGION_W = 2;
    localparam int BIDX_W   = 6;
    localparam int CNT_W    = 32;
    localparam int BCNT_W   = 7;
    localparam int BWID_W   = 24;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [BCNT_W-1:0] NBKT_RESET = 7'd32;
    localparam logic [BWID_W-1:0] BUCKET_WIDTH_RESET = 24'd1000;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

    // region codes
    localparam logic [REGION_W-1:0] R_IN    = 2'd0;
    localparam logic [REGION_W-1:0] R_BELOW = 2'd1;
    localparam logic [REGION_W-1:0] R_ABOVE = 2'd2;
    localparam logic [REGION_W-1:0] R_NONE  = 2'd3;

    // register indexes (word address bit 2)
    localparam logic CFG_NBKT         = 1'b0;
    localparam logic CFG_BUCKET_WIDTH = 1'b1;

    typedef enum logic [3:0] {
        ST_FETCH,
        ST_MHALF,
        ST_MFULL,
        ST_CMP,
        ST_DIV,
        ST_BADDR,
        ST_BWAIT,
        ST_BINC,
        ST_SIDE,
        ST_RADDR,
        ST_RWAIT,
        ST_RSEL,
        ST_CLR,
        ST_NONE,
        ST_EMIT
    } step_t;

    typedef enum logic [3:0] {
        U_NOP,
        U_FETCH,
        U_MHALF,
        U_MFULL,
        U_CMP,
        U_DIV,
        U_BADDR,
        U_BINC,
        U_SIDE,
        U_RADDR,
        U_RSEL,
        U_CLR,
        U_NONE,
        U_EMIT
    } uop_t;

    typedef enum logic [2:0] {
        J_NEXT,
        J_ALWAYS,
        J_DISPATCH,
        J_OUTSIDE,
        J_DIV_LOOP,
        J_OUT_FREE
    } jcond_t;

    typedef struct packed {
        uop_t   uop;
        jcond_t jc;
        step_t  target;
    } ctrl_t;

    // sequencer program, one control word per step
    function automatic ctrl_t ucode_rom(input step_t s);
        ctrl_t w;
        unique case (s)
            ST_FETCH: w = '{U_FETCH, J_DISPATCH, ST_FETCH};
            ST_MHALF: w = '{U_MHALF, J_NEXT,     ST_FETCH};
            ST_MFULL: w = '{U_MFULL, J_NEXT,     ST_FETCH};
            ST_CMP:   w = '{U_CMP,   J_OUTSIDE,  ST_SIDE};
            ST_DIV:   w = '{U_DIV,   J_DIV_LOOP, ST_FETCH};
            ST_BADDR: w = '{U_BADDR, J_NEXT,     ST_FETCH};
            ST_BWAIT: w = '{U_NOP,   J_NEXT,     ST_FETCH};
            ST_BINC:  w = '{U_BINC,  J_ALWAYS,   ST_EMIT};
            ST_SIDE:  w = '{U_SIDE,  J_ALWAYS,   ST_EMIT};
            ST_RADDR: w = '{U_RADDR, J_NEXT,     ST_FETCH};
            ST_RWAIT: w = '{U_NOP,   J_NEXT,     ST_FETCH};
            ST_RSEL:  w = '{U_RSEL,  J_ALWAYS,   ST_EMIT};
            ST_CLR:   w = '{U_CLR,   J_ALWAYS,   ST_EMIT};
            ST_NONE:  w = '{U_NONE,  J_ALWAYS,   ST_EMIT};
            ST_EMIT:  w = '{U_EMIT,  J_OUT_FREE, ST_FETCH};
            default:  w = '{U_NOP,   J_ALWAYS,   ST_FETCH};
        endcase
        return w;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

>>> hw/rtl/signed_offset_histogram_unit.sv
// ============================================================================
// signed_offset_histogram_unit: histogram of signed timing errors
// Microcoded sequencer over a shared multiplier, a restoring divider and a
// single-port counter memory with per-entry valid bits.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready) carries op, error_value, read_index.
//   Output channel (out_valid/out_ready) carries region, bucket_index and
//   count_value, one result beat per input beat, in order.
//   APB port: register 0 bucket count at 0x0, register 1 bucket_width at 0x4.
//   Write only while the block is idle.
// Steps, from acceptance to the result register: add, in range: products,
//   compare, QW quotient bits of the serial divider, one bit per cycle,
//   bucket address, registered memory read, increment; add, out of range:
//   products, compare, side counter update; read: address, registered
//   memory read, select; clear or no-op: the clear or no-op step. One item
//   is in work at a time; the next one is taken the cycle after its result
//   is loaded into the output register.
// Reset zeroes every counter, buckets at once via valid bits; registers take
// their reset values. When the receiver stalls, the finished result holds in
// the output register, the next item is accepted and worked, and the
// sequencer waits in its emit step until the output register is free.
// ============================================================================
module signed_offset_histogram_unit
    import sohist_pkg::*;
#(
    parameter int MAX_BUCKETS = MAX_BUCKETS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [OP_W-1:0]      op,
    input  logic signed [ERR_W-1:0] error_value,
    input  logic [RIDX_W-1:0]    read_index,
    // output channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [REGION_W-1:0]  region,
    output logic [BIDX_W-1:0]    bucket_index,
    output logic [CNT_W-1:0]     count_value,
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int AW   = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int NMAX = (MAX_BUCKETS < 127) ? MAX_BUCKETS : 127;
    localparam int NW   = $clog2(NMAX + 1);
    localparam int QW   = (NMAX > 1) ? $clog2(NMAX) : 1;
    localparam int CW   = (QW > 1) ? $clog2(QW) : 1;
    localparam int PW   = NW + BWID_W;
    localparam int SW   = ((PW > ERR_W) ? PW : ERR_W) + 2;

    // configuration registers
    logic [BCNT_W-1:0] nbkt_reg;
    logic [BWID_W-1:0] bucket_width_reg;

    // sequencer
    step_t step_reg;
    step_t step_next;
    ctrl_t ctrl;

    // latched input beat
    logic signed [ERR_W-1:0]  err_reg;
    logic [RIDX_W-1:0]        ridx_reg;

    // datapath
    logic [PW-1:0]            prod_reg;
    logic signed [SW-1:0]     start_reg;
    logic [PW-1:0]            rem_reg;
    logic [PW-1:0]            dvs_reg;
    logic [QW-1:0]            quo_reg;
    logic [CW-1:0]            div_cnt_reg;
    logic [AW-1:0]            addr_reg;

    logic [CNT_W-1:0]         below_reg;
    logic [CNT_W-1:0]         above_reg;
    logic [CNT_W-1:0]         total_reg;

    // pending result
    logic [REGION_W-1:0]      res_region_reg;
    logic [BIDX_W-1:0]        res_bidx_reg;
    logic [CNT_W-1:0]         res_count_reg;

    // output register
    logic                     out_valid_reg;
    logic [REGION_W-1:0]      region_reg;
    logic [BIDX_W-1:0]        bidx_reg;
    logic [CNT_W-1:0]         count_reg;

    // counter memory
    logic [CNT_W-1:0]         mem [MAX_BUCKETS];
    logic [CNT_W-1:0]         mem_rd_reg;
    logic [MAX_BUCKETS-1:0]   vld_reg;
    logic                     vld_rd_reg;
    logic                     mem_we;
    logic [CNT_W-1:0]         mem_wdata;

    // combinational datapath
    logic [BCNT_W-1:0]        cnt_nz;
    logic [NW-1:0]            n_eff;
    logic [BWID_W-1:0]        w_eff;
    logic [NW-1:0]            mul_a;
    logic [PW-1:0]            prod_mul;
    logic signed [SW-1:0]     e_ext;
    logic signed [SW-1:0]     end_val;
    logic signed [SW-1:0]     diff;
    logic                     is_below;
    logic                     is_above;
    logic                     ge;
    logic [QW-1:0]            k_clamp;
    logic [CNT_W-1:0]         bkt_cur;
    logic [CNT_W-1:0]         rd_count;
    logic                     in_accept;
    logic                     out_free;
    logic                     cfg_we;

    assign ctrl      = ucode_rom(step_reg);
    assign in_ready  = (step_reg == ST_FETCH);
    assign in_accept = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign region       = region_reg;
    assign bucket_index = bidx_reg;
    assign count_value  = count_reg;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            CFG_NBKT:         prdata = 32'(nbkt_reg);
            CFG_BUCKET_WIDTH: prdata = 32'(bucket_width_reg);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // datapath logic
    // ------------------------------------------------------------------
    always_comb
    begin
        cnt_nz = (nbkt_reg == '0) ? BCNT_W'(1) : nbkt_reg;
        if (32'(cnt_nz) > 32'(MAX_BUCKETS))
        begin
            n_eff = NW'(NMAX);
        end
        else
        begin
            n_eff = NW'(cnt_nz);
        end
        w_eff = (bucket_width_reg == '0) ? BWID_W'(1) : bucket_width_reg;

        mul_a    = (ctrl.uop == U_MHALF) ? (n_eff >> 1) : n_eff;
        prod_mul = PW'(mul_a) * PW'(w_eff);

        e_ext    = SW'(err_reg);
        end_val  = start_reg + $signed(SW'(prod_reg));
        diff     = e_ext - start_reg;
        is_below = (e_ext < start_reg);
        is_above = !is_below && (e_ext >= end_val);

        ge = (rem_reg >= dvs_reg);

        // quotient past the last bucket folds into it
        if (32'(quo_reg) >= 32'(n_eff))
        begin
            k_clamp = QW'(n_eff - 1'b1);
        end
        else
        begin
            k_clamp = quo_reg;
        end

        bkt_cur   = vld_rd_reg ? mem_rd_reg : '0;
        mem_we    = (ctrl.uop == U_BINC);
        mem_wdata = sat_inc(bkt_cur);

        if (32'(ridx_reg) < 32'(MAX_BUCKETS))
        begin
            rd_count = bkt_cur;
        end
        else if (32'(ridx_reg) == 32'(MAX_BUCKETS))
        begin
            rd_count = below_reg;
        end
        else if (32'(ridx_reg) == 32'(MAX_BUCKETS) + 32'd1)
        begin
            rd_count = above_reg;
        end
        else if (32'(ridx_reg) == 32'(MAX_BUCKETS) + 32'd2)
        begin
            rd_count = total_reg;
        end
        else
        begin
            rd_count = '0;
        end
    end

    // ------------------------------------------------------------------
    // step sequencing
    // ------------------------------------------------------------------
    always_comb
    begin
        step_next = step_reg;
        unique case (ctrl.jc)
            J_NEXT:   step_next = step_t'(step_reg + 4'd1);
            J_ALWAYS: step_next = ctrl.target;
            J_DISPATCH:
            begin
                if (in_accept)
                begin
                    unique case (op)
                        OP_ADD:   step_next = ST_MHALF;
                        OP_READ:  step_next = ST_RADDR;
                        OP_CLEAR: step_next = ST_CLR;
                        default:  step_next = ST_NONE;
                    endcase
                end
            end
            J_OUTSIDE:
            begin
                step_next = (is_below || is_above) ? ctrl.target
                                                   : step_t'(step_reg + 4'd1);
            end
            J_DIV_LOOP:
            begin
                if (div_cnt_reg == '0)
                begin
                    step_next = step_t'(step_reg + 4'd1);
                end
            end
            J_OUT_FREE:
            begin
                if (out_free)
                begin
                    step_next = ctrl.target;
                end
            end
            default:  step_next = ST_FETCH;
        endcase
    end

    // ------------------------------------------------------------------
    // control state, counters and output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg         <= ST_FETCH;
            nbkt_reg         <= NBKT_RESET;
            bucket_width_reg <= BUCKET_WIDTH_RESET;
            below_reg        <= '0;
            above_reg        <= '0;
            total_reg        <= '0;
            vld_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;

            if (cfg_we)
            begin
                unique case (paddr[2])
                    CFG_NBKT:         nbkt_reg <= pwdata[BCNT_W-1:0];
                    CFG_BUCKET_WIDTH: bucket_width_reg <= pwdata[BWID_W-1:0];
                    default: ;
                endcase
            end

            if ((ctrl.uop == U_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (ctrl.uop)
                U_CMP:
                begin
                    total_reg <= sat_inc(total_reg);
                end
                U_BINC:
                begin
                    vld_reg[addr_reg] <= 1'b1;
                end
                U_SIDE:
                begin
                    if (res_region_reg == R_BELOW)
                    begin
                        below_reg <= sat_inc(below_reg);
                    end
                    else
                    begin
                        above_reg <= sat_inc(above_reg);
                    end
                end
                U_CLR:
                begin
                    vld_reg   <= '0;
                    below_reg <= '0;
                    above_reg <= '0;
                    total_reg <= '0;
                end
                default: ;
            endcase
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        case (ctrl.uop)
            U_FETCH:
            begin
                if (in_accept)
                begin
                    err_reg  <= error_value;
                    ridx_reg <= read_index;
                end
            end
            U_MHALF:
            begin
                prod_reg <= prod_mul;
            end
            U_MFULL:
            begin
                start_reg <= -$signed(SW'(prod_reg));
                prod_reg  <= prod_mul;
            end
            U_CMP:
            begin
                rem_reg     <= PW'(diff);
                dvs_reg     <= PW'(w_eff) << (QW - 1);
                quo_reg     <= '0;
                div_cnt_reg <= CW'(QW - 1);
                res_bidx_reg <= '0;
                if (is_below)
                begin
                    res_region_reg <= R_BELOW;
                end
                else if (is_above)
                begin
                    res_region_reg <= R_ABOVE;
                end
                else
                begin
                    res_region_reg <= R_IN;
                end
            end
            U_DIV:
            begin
                // restoring divide, one quotient bit a step
                if (ge)
                begin
                    rem_reg <= rem_reg - dvs_reg;
                end
                quo_reg     <= QW'({quo_reg, ge});
                dvs_reg     <= dvs_reg >> 1;
                div_cnt_reg <= div_cnt_reg - 1'b1;
            end
            U_BADDR:
            begin
                addr_reg     <= AW'(k_clamp);
                res_bidx_reg <= BIDX_W'(k_clamp);
            end
            U_BINC:
            begin
                res_count_reg <= mem_wdata;
            end
            U_SIDE:
            begin
                res_count_reg <= (res_region_reg == R_BELOW) ? sat_inc(below_reg)
                                                             : sat_inc(above_reg);
            end
            U_RADDR:
            begin
                addr_reg       <= AW'(ridx_reg);
                res_region_reg <= R_NONE;
                res_bidx_reg   <= '0;
            end
            U_RSEL:
            begin
                res_count_reg <= rd_count;
            end
            U_CLR, U_NONE:
            begin
                res_region_reg <= R_NONE;
                res_bidx_reg   <= '0;
                res_count_reg  <= '0;
            end
            U_EMIT:
            begin
                if (out_free)
                begin
                    region_reg <= res_region_reg;
                    bidx_reg   <= res_bidx_reg;
                    count_reg  <= res_count_reg;
                end
            end
            default: ;
        endcase
    end

    // counter memory: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr_reg] <= mem_wdata;
        end
        mem_rd_reg <= mem[addr_reg];
        vld_rd_reg <= vld_reg[addr_reg];
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // divider remainder stays below twice the current trial divisor
    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == ST_DIV) |-> ({1'b0, rem_reg} < {dvs_reg, 1'b0}))
        else $error("divider remainder out of bound");

    // an out-of-range or non-sample result never carries a bucket index
    a_bidx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && region != R_IN) |-> (bucket_index == '0))
        else $error("bucket index set outside range");

    // an in-range result names a bucket in use
    a_bidx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && region == R_IN) |-> (32'(bucket_index) < 32'(n_eff)))
        else $error("bucket index beyond bucket count");

    // clear leaves the total counter at zero
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == ST_CLR) |=> (total_reg == '0))
        else $error("total counter not cleared");

endmodule

>>> test/signed_offset_histogram_unit_test.sv
`timescale 1ns / 1ps
// ============================================================================
// signed_offset_histogram_unit_test: self-checking bench for the histogram
// Feeds add, read, clear and no-op beats through the input channel, keeps its
// own copy of the bucket, below, above and total tallies, and checks every
// result beat in order. Runs under several bucket count and width settings,
// with random gaps on both channels and long receiver stalls.
// ============================================================================
module signed_offset_histogram_unit_test;
    import sohist_pkg::*;

    localparam int HIST_BINS       = MAX_BUCKETS_DEFAULT;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 32;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int PHASE_BEATS     = 200;
    localparam int MAX_PRINTS      = 60;

    typedef struct {
        logic [OP_W-1:0]         op;
        logic signed [ERR_W-1:0] err;
        logic [RIDX_W-1:0]       ridx;
    } hist_req_t;

    typedef struct {
        logic [REGION_W-1:0] region;
        logic [BIDX_W-1:0]   bidx;
        logic [CNT_W-1:0]    count;
    } hist_rsp_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [OP_W-1:0]         op = OP_NOP;
    logic signed [ERR_W-1:0] error_value = '0;
    logic [RIDX_W-1:0]       read_index = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [REGION_W-1:0]     region;
    logic [BIDX_W-1:0]       bucket_index;
    logic [CNT_W-1:0]        count_value;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [2:0]              paddr = '0;
    logic [31:0]             pwdata = '0;
    logic [31:0]             prdata;
    logic                    pready;

    // shadow of the block's registers and tallies
    logic [BCNT_W-1:0] cfg_count = NBKT_RESET;
    logic [BWID_W-1:0] cfg_width = BUCKET_WIDTH_RESET;
    logic [CNT_W-1:0]  bin_tally [HIST_BINS];
    logic [CNT_W-1:0]  below_tally = '0;
    logic [CNT_W-1:0]  above_tally = '0;
    logic [CNT_W-1:0]  sample_total = '0;

    hist_req_t   pending_beats [$];
    hist_rsp_t   predicted_tallies [$];
    int unsigned beats_queued = 0;
    int unsigned beats_taken = 0;
    int unsigned results_seen = 0;
    int unsigned fail_count = 0;
    int unsigned send_wait = 0;
    int unsigned recv_wait = 0;
    int unsigned quiet_cycles = 0;
    logic        send_burst = 1'b0;
    logic        recv_burst = 1'b0;

    signed_offset_histogram_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .error_value  (error_value),
        .read_index   (read_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .region       (region),
        .bucket_index (bucket_index),
        .count_value  (count_value),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #2 clk = ~clk;

    initial
    begin
        foreach (bin_tally[i])
            bin_tally[i] = '0;
    end

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= MAX_PRINTS)
            $display("ERROR t=%0t %s", $realtime, what);
    endtask

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // effective bucket count, width and range bounds under the current setting
    function automatic void range_now(output longint n, output longint w,
                                      output longint lo, output longint hi);
        n = (cfg_count == 0) ? 1 : longint'(cfg_count);
        if (n > HIST_BINS)
            n = HIST_BINS;
        w = (cfg_width == 0) ? 1 : longint'(cfg_width);
        lo = -(n / 2) * w;
        hi = lo + n * w;
    endfunction

    function automatic hist_rsp_t tally_request(input hist_req_t rq);
        hist_rsp_t rs;
        longint    n, w, lo, hi, e, k;
        rs.region = R_NONE;
        rs.bidx = '0;
        rs.count = '0;
        range_now(n, w, lo, hi);
        e = rq.err;
        case (rq.op)
            OP_ADD:
            begin
                sample_total = bump(sample_total);
                if (e < lo)
                begin
                    below_tally = bump(below_tally);
                    rs.region = R_BELOW;
                    rs.count = below_tally;
                end
                else if (e >= hi)
                begin
                    above_tally = bump(above_tally);
                    rs.region = R_ABOVE;
                    rs.count = above_tally;
                end
                else
                begin
                    k = (e - lo) / w;
                    if (k >= n)
                        k = n - 1;
                    bin_tally[k] = bump(bin_tally[k]);
                    rs.region = R_IN;
                    rs.bidx = k[BIDX_W-1:0];
                    rs.count = bin_tally[k];
                end
            end
            OP_READ:
            begin
                if (rq.ridx < HIST_BINS)
                    rs.count = bin_tally[rq.ridx];
                else if (rq.ridx == HIST_BINS)
                    rs.count = below_tally;
                else if (rq.ridx == HIST_BINS + 1)
                    rs.count = above_tally;
                else if (rq.ridx == HIST_BINS + 2)
                    rs.count = sample_total;
            end
            OP_CLEAR:
            begin
                foreach (bin_tally[i])
                    bin_tally[i] = '0;
                below_tally = '0;
                above_tally = '0;
                sample_total = '0;
            end
            default:
            begin
            end
        endcase
        return rs;
    endfunction

    function automatic hist_req_t make_req(input logic [OP_W-1:0] o,
                                           input logic [ERR_W-1:0] e,
                                           input logic [RIDX_W-1:0] r);
        hist_req_t rq;
        rq.op = o;
        rq.err = e;
        rq.ridx = r;
        return rq;
    endfunction

    // mostly samples aimed at and around the current range
    function automatic hist_req_t random_request();
        hist_req_t rq;
        longint    n, w, lo, hi, v;
        int        pick;
        range_now(n, w, lo, hi);
        pick = $urandom_range(0, 99);
        if (pick < 65)
            rq.op = OP_ADD;
        else if (pick < 92)
            rq.op = OP_READ;
        else if (pick < 94)
            rq.op = OP_CLEAR;
        else
            rq.op = OP_NOP;
        rq.ridx = RIDX_W'(($urandom_range(0, 9) == 0) ? $urandom_range(67, 127)
                                                      : $urandom_range(0, 66));
        pick = $urandom_range(0, 9);
        if (pick < 2)
            v = $urandom;
        else if (pick == 2)
        begin
            case ($urandom_range(0, 3))
                0: v = lo - 1;
                1: v = lo;
                2: v = hi - 1;
                default: v = hi;
            endcase
        end
        else
        begin
            v = $urandom_range(0, n + 1);
            v = lo + (v - 1) * w + $urandom_range(0, w - 1);
        end
        rq.err = v[ERR_W-1:0];
        return rq;
    endfunction

    task automatic queue_beat(input hist_req_t rq);
        pending_beats.insert(pending_beats.size(), rq);
        beats_queued++;
    endtask

    // wait until every queued beat is taken and every result is back
    task automatic drain();
        while (beats_taken != beats_queued || predicted_tallies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic idx, input logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == CFG_NBKT)
            cfg_count = data[BCNT_W-1:0];
        else
            cfg_width = data[BWID_W-1:0];
    endtask

    // upper data bits are junk the register must drop
    task automatic run_phase(input logic [BCNT_W-1:0] cnt, input logic [BWID_W-1:0] wid,
                             input int beats);
        drain();
        reg_write(CFG_NBKT, ($urandom & ~32'h7F) | cnt);
        reg_write(CFG_BUCKET_WIDTH, ($urandom & 32'hFF00_0000) | wid);
        repeat (beats) queue_beat(random_request());
        drain();
    endtask

    // input side
    always @(posedge clk or negedge rst_n)
    begin
        hist_req_t rq;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_wait <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                rq.op = op;
                rq.err = error_value;
                rq.ridx = read_index;
                predicted_tallies.insert(predicted_tallies.size(), tally_request(rq));
                beats_taken++;
                if ($urandom_range(0, 39) == 0)
                    send_burst <= !send_burst;
            end
            if (!in_valid || in_ready)
            begin
                if (send_wait != 0)
                begin
                    send_wait <= send_wait - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_beats.size() != 0)
                begin
                    rq = pending_beats.pop_front();
                    op <= rq.op;
                    error_value <= rq.err;
                    read_index <= rq.ridx;
                    in_valid <= 1'b1;
                    send_wait <= send_burst ? 0 : $urandom_range(0, 16);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // output side: check each beat, then stall at random
    always @(posedge clk or negedge rst_n)
    begin
        hist_rsp_t   want;
        int unsigned wait_n;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_wait <= 0;
        end
        else
        begin
            wait_n = recv_wait;
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (predicted_tallies.size() == 0)
                    report_mismatch($sformatf("beat %0d with nothing expected", results_seen));
                else
                begin
                    want = predicted_tallies.pop_front();
                    if (region !== want.region)
                        report_mismatch($sformatf("beat %0d region: got %0d want %0d",
                                                  results_seen, region, want.region));
                    if (bucket_index !== want.bidx)
                        report_mismatch($sformatf("beat %0d bucket_index: got %0d want %0d",
                                                  results_seen, bucket_index, want.bidx));
                    if (count_value !== want.count)
                        report_mismatch($sformatf("beat %0d count_value: got %0d want %0d",
                                                  results_seen, count_value, want.count));
                end
                wait_n = recv_burst ? 0 : $urandom_range(0, 16);
                // long hold so the block backs up and stalls its input
                if (results_seen == 300 || results_seen == 1200)
                    wait_n += HOLD_CYCLES;
                if ($urandom_range(0, 39) == 0)
                    recv_burst <= !recv_burst;
            end
            if (wait_n != 0)
            begin
                out_ready <= 1'b0;
                recv_wait <= wait_n - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                recv_wait <= 0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("signed_offset_histogram_unit: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: 32 buckets of 1000, range [-16000, 16000)
        queue_beat(make_req(OP_READ, 32'h1234_5678, 7'd66));
        queue_beat(make_req(OP_READ, 32'hFFFF_FFFF, 7'd64));
        queue_beat(make_req(OP_ADD, 32'd0, 7'd127));
        queue_beat(make_req(OP_ADD, 32'h8000_0000, 7'd0));
        queue_beat(make_req(OP_ADD, 32'h7FFF_FFFF, 7'd0));
        queue_beat(make_req(OP_ADD, -32'sd16000, 7'd0));
        queue_beat(make_req(OP_ADD, -32'sd16001, 7'd0));
        queue_beat(make_req(OP_ADD, 32'sd15999, 7'd0));
        queue_beat(make_req(OP_ADD, 32'sd16000, 7'd0));
        queue_beat(make_req(OP_ADD, -32'sd1, 7'd0));
        queue_beat(make_req(OP_ADD, 32'sd999, 7'd0));
        queue_beat(make_req(OP_READ, 32'd0, 7'd16));
        queue_beat(make_req(OP_READ, 32'd0, 7'd65));
        queue_beat(make_req(OP_READ, 32'd0, 7'd66));
        queue_beat(make_req(OP_READ, 32'd0, 7'd63));
        queue_beat(make_req(OP_READ, 32'd0, 7'd67));
        queue_beat(make_req(OP_READ, 32'hFFFF_FFFF, 7'd127));
        queue_beat(make_req(OP_NOP, 32'hA5A5_5A5A, 7'd66));
        queue_beat(make_req(OP_CLEAR, 32'h7FFF_FFFF, 7'd64));
        queue_beat(make_req(OP_READ, 32'd0, 7'd66));
        queue_beat(make_req(OP_READ, 32'd0, 7'd16));
        queue_beat(make_req(OP_ADD, 32'h8000_0000, 7'd0));

        run_phase(7'd1, 24'd1, PHASE_BEATS);
        run_phase(7'd64, 24'hFF_FFFF, PHASE_BEATS);
        run_phase(7'd0, 24'd0, PHASE_BEATS);
        run_phase(7'd127, 24'd7, PHASE_BEATS);
        run_phase(7'd5, 24'd3, PHASE_BEATS);
        run_phase(7'd64, 24'd1, PHASE_BEATS);
        run_phase(7'd2, 24'hFF_FFFF, PHASE_BEATS);
        run_phase(7'd33, 24'd250, PHASE_BEATS);
        run_phase(BCNT_W'($urandom_range(1, 64)), BWID_W'($urandom_range(1, 5000)),
                  PHASE_BEATS);
        drain();

        if (fail_count == 0)
            $display("signed_offset_histogram_unit: match");
        else
            $display("signed_offset_histogram_unit: mismatch");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/sohist_pkg.sv
hw/rtl/signed_offset_histogram_unit.sv
test/signed_offset_histogram_unit_test.sv
